>>> rtl/rwlt_pkg.sv
// Package for the reader-writer lock table: lock word layout, operation codes,
// step result type and field limits. No dependencies.
`timescale 1ns / 1ps

package rwlt_pkg;

  // Operation codes carried in the kind field. Code 7 is unused.
  typedef enum logic [2:0] {
    KIND_CLEAR       = 3'd0,
    KIND_TRY_EXCL    = 3'd1,
    KIND_REG_WRITER  = 3'd2,
    KIND_CLAIM_EXCL  = 3'd3,
    KIND_REL_EXCL    = 3'd4,
    KIND_TRY_SHARED  = 3'd5,
    KIND_REL_SHARED  = 3'd6
  } kind_t;

  // One lock word, most significant field first.
  typedef struct packed {
    logic [15:0] waiting;
    logic        excl;
    logic [14:0] readers;
  } lock_word_t;

  // Outcome of one step on a lock word.
  typedef struct packed {
    logic       granted;
    logic       misuse;
    lock_word_t word;
  } step_result_t;

  localparam logic [14:0] READERS_MAX = 15'h7fff;
  localparam logic [15:0] WAITING_MAX = 16'hffff;

endpackage

>>> rtl/rwlt_if.sv
// Handshake channels of the lock table: request words in, result words out.
// No dependencies.
`timescale 1ns / 1ps

interface rwlt_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [5:0] lock_index;

  modport source (output valid, output kind, output lock_index, input ready);
  modport sink   (input valid, input kind, input lock_index, output ready);
endinterface

interface rwlt_out_if;
  logic        valid;
  logic        ready;
  logic        granted;
  logic        misuse;
  logic [14:0] reader_count;
  logic        exclusive_held;
  logic [15:0] waiting_writers;

  modport source (output valid, output granted, output misuse, output reader_count,
                  output exclusive_held, output waiting_writers, input ready);
  modport sink   (input valid, input granted, input misuse, input reader_count,
                  input exclusive_held, input waiting_writers, output ready);
endinterface

>>> rtl/rwlt_mem.sv
// Lock word memory: one write port, one registered read port, per-entry
// valid bits so that unwritten entries read as a free lock. Uses rwlt_pkg.
`timescale 1ns / 1ps

module rwlt_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output rwlt_pkg::lock_word_t rd_word,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  rwlt_pkg::lock_word_t wr_word
);
  import rwlt_pkg::*;

  lock_word_t       mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  lock_word_t       rd_q_r;
  logic             rd_vld_r;

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_word;
    end
  end

  // Valid bits: reset frees every lock at once.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Registered read of the word and of its valid bit.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  assign rd_word = rd_vld_r ? rd_q_r : '0;

endmodule

>>> rtl/rwlt_alu.sv
// Lock step logic: applies one operation to a lock word and reports the
// grant, misuse and new word. Uses rwlt_pkg.
`timescale 1ns / 1ps

module rwlt_alu (
  input  logic [2:0]             kind,
  input  rwlt_pkg::lock_word_t   cur,
  output rwlt_pkg::step_result_t res
);
  import rwlt_pkg::*;

  always_comb begin
    res.granted = 1'b0;
    res.misuse  = 1'b0;
    res.word    = cur;
    case (kind_t'(kind))
      KIND_CLEAR: begin
        res.word    = '0;
        res.granted = 1'b1;
      end
      KIND_TRY_EXCL: begin
        if (cur.readers == '0 && !cur.excl) begin
          res.word.excl = 1'b1;
          res.granted   = 1'b1;
        end
      end
      KIND_REG_WRITER: begin
        if (cur.waiting != WAITING_MAX) begin
          res.word.waiting = cur.waiting + 16'd1;
          res.granted      = 1'b1;
        end
      end
      KIND_CLAIM_EXCL: begin
        // Claiming without a registered writer is misuse.
        if (cur.waiting == '0) begin
          res.misuse = 1'b1;
        end else if (cur.readers == '0 && !cur.excl) begin
          res.word.waiting = cur.waiting - 16'd1;
          res.word.excl    = 1'b1;
          res.granted      = 1'b1;
        end
      end
      KIND_REL_EXCL: begin
        if (!cur.excl) begin
          res.misuse = 1'b1;
        end else begin
          res.word.excl = 1'b0;
          res.granted   = 1'b1;
        end
      end
      KIND_TRY_SHARED: begin
        // Waiting writers keep new readers out.
        if (cur.waiting == '0 && !cur.excl && cur.readers != READERS_MAX) begin
          res.word.readers = cur.readers + 15'd1;
          res.granted      = 1'b1;
        end
      end
      KIND_REL_SHARED: begin
        if (cur.readers == '0) begin
          res.misuse = 1'b1;
        end else begin
          res.word.readers = cur.readers - 15'd1;
          res.granted      = 1'b1;
        end
      end
      default: begin
        // Unused code: word shown unchanged, nothing granted.
      end
    endcase
  end

endmodule

>>> rtl/reader_writer_lock_table_unit.sv
// Top level of the reader-writer lock table: request handshake, memory
// read-modify-write and result register. Uses rwlt_pkg, rwlt_if, rwlt_mem, rwlt_alu.
//
//   channel   direction  word contents
//   in_ch     in         kind, lock_index
//   out_ch    out        granted, misuse, reader_count, exclusive_held, waiting_writers
//
// Each request reads the lock word in the accept cycle and modifies and writes it
// back in the next, behind the registered memory read.
// Only one request is in flight, so a write never overlaps a read of its entry.
// Reset frees all locks at once through per-entry valid bits.
// A stalled result holds in the output register; a new request is taken in the
// same cycle that the waiting result word is taken.
`timescale 1ns / 1ps

module reader_writer_lock_table_unit #(
  parameter int LOCK_COUNT = 64
) (
  input logic       clk,
  input logic       rst_n,
  rwlt_in_if.sink   in_ch,
  rwlt_out_if.source out_ch
);
  import rwlt_pkg::*;

  // Only the first 64 locks are reachable through a 6-bit index.
  localparam int DEPTH = (LOCK_COUNT > 64) ? 64 : LOCK_COUNT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          busy_r;
  logic          out_valid_r;
  logic [2:0]    kind_r;
  logic [AW-1:0] addr_r;
  logic          in_range_r;
  logic          in_fire;
  logic          in_range;
  lock_word_t    cur_word;
  step_result_t  step_res;
  logic          granted_r;
  logic          misuse_r;
  lock_word_t    word_r;

  // Accept only when no request is in flight and the result register frees up.
  assign in_ch.ready = !busy_r && (!out_valid_r || out_ch.ready);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = int'(in_ch.lock_index) < LOCK_COUNT;

  rwlt_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && in_range),
    .rd_addr (in_ch.lock_index[AW-1:0]),
    .rd_word (cur_word),
    .wr_en   (busy_r && in_range_r),
    .wr_addr (addr_r),
    .wr_word (step_res.word)
  );

  rwlt_alu u_alu (
    .kind (kind_r),
    .cur  (cur_word),
    .res  (step_res)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= in_fire;
      if (busy_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= in_ch.kind;
      addr_r     <= in_ch.lock_index[AW-1:0];
      in_range_r <= in_range;
    end
  end

  // Result register; a request beyond the table reports all zero.
  always_ff @(posedge clk) begin
    if (busy_r) begin
      if (in_range_r) begin
        granted_r <= step_res.granted;
        misuse_r  <= step_res.misuse;
        word_r    <= step_res.word;
      end else begin
        granted_r <= 1'b0;
        misuse_r  <= 1'b0;
        word_r    <= '0;
      end
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.granted         = granted_r;
  assign out_ch.misuse          = misuse_r;
  assign out_ch.reader_count    = word_r.readers;
  assign out_ch.exclusive_held  = word_r.excl;
  assign out_ch.waiting_writers = word_r.waiting;

  // An accepted request is worked in exactly the next cycle.
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> busy_r)
    else $error("accepted request not processed next cycle");

  // The modify cycle always produces a result word.
  a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |=> (out_valid_r && !busy_r))
    else $error("modify cycle did not load the result register");

  // A result never reports both a grant and misuse.
  a_grant_misuse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(granted_r && misuse_r))
    else $error("result both granted and misuse");

  // A request beyond the table never leaves a nonzero result.
  a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !in_range_r) |=> (word_r == '0 && !granted_r && !misuse_r))
    else $error("out-of-range request produced a nonzero result");

endmodule

>>> verif/rwlt_lock_checker.sv
// Scoreboard for the reader-writer lock table: keeps its own copy of every lock
// word, predicts each result word and checks it. Depends on rwlt_pkg and rwlt_if.
`timescale 1ns / 1ps

module rwlt_lock_checker #(
  parameter int LOCK_COUNT = 64
) (
  input  logic clk,
  input  logic rst_n,
  rwlt_in_if   in_ch,
  rwlt_out_if  out_ch,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   granted_seen,
  output int   misuse_seen
);
  import rwlt_pkg::*;

  // Shadow copy of the lock table and the results still owed by the block.
  lock_word_t   lock_shadow [LOCK_COUNT];
  step_result_t owed_results [$];

  // Applies one operation to a lock word. Refused and misused requests keep
  // the word; an unused code is ignored and reports the word as it stands.
  function automatic step_result_t apply_lock_op(input logic [2:0] op, input lock_word_t w);
    step_result_t r;
    r.granted = 1'b0;
    r.misuse  = 1'b0;
    r.word    = w;
    case (op)
      KIND_CLEAR: begin
        r.word    = '0;
        r.granted = 1'b1;
      end
      KIND_TRY_EXCL: begin
        // Waiting writers do not block a direct exclusive attempt.
        if (w.readers == '0 && !w.excl) begin
          r.word.excl = 1'b1;
          r.granted   = 1'b1;
        end
      end
      KIND_REG_WRITER: begin
        if (w.waiting != WAITING_MAX) begin
          r.word.waiting = w.waiting + 16'd1;
          r.granted      = 1'b1;
        end
      end
      KIND_CLAIM_EXCL: begin
        if (w.waiting == '0) begin
          r.misuse = 1'b1;
        end else if (w.readers == '0 && !w.excl) begin
          r.word.waiting = w.waiting - 16'd1;
          r.word.excl    = 1'b1;
          r.granted      = 1'b1;
        end
      end
      KIND_REL_EXCL: begin
        if (!w.excl) begin
          r.misuse = 1'b1;
        end else begin
          r.word.excl = 1'b0;
          r.granted   = 1'b1;
        end
      end
      KIND_TRY_SHARED: begin
        // Writer preference: any waiting writer keeps new readers out.
        if (w.waiting == '0 && !w.excl && w.readers != READERS_MAX) begin
          r.word.readers = w.readers + 15'd1;
          r.granted      = 1'b1;
        end
      end
      KIND_REL_SHARED: begin
        if (w.readers == '0) begin
          r.misuse = 1'b1;
        end else begin
          r.word.readers = w.readers - 15'd1;
          r.granted      = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      fail_count++;
      $display("%0t: result word %0d, %s expected %0d, actual %0d",
               $time, results_seen, name, want, got);
    end
  endtask

  // Results are matched before requests are booked, so a result can never be
  // paired with a request taken at the same edge.
  always @(posedge clk) begin : track
    step_result_t want;
    logic [5:0]   idx;
    if (!rst_n) begin
      foreach (lock_shadow[i]) lock_shadow[i] = '0;
      owed_results.delete();
      fail_count   = 0;
      pending      = 0;
      results_seen = 0;
      granted_seen = 0;
      misuse_seen  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (out_ch.granted) granted_seen++;
        if (out_ch.misuse) misuse_seen++;
        if (owed_results.size() == 0) begin
          fail_count++;
          $display("%0t: result word %0d arrived with no request outstanding",
                   $time, results_seen);
        end else begin
          want = owed_results.pop_front();
          check_field("granted", want.granted, out_ch.granted);
          check_field("misuse", want.misuse, out_ch.misuse);
          check_field("reader_count", want.word.readers, out_ch.reader_count);
          check_field("exclusive_held", want.word.excl, out_ch.exclusive_held);
          check_field("waiting_writers", want.word.waiting, out_ch.waiting_writers);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        idx = in_ch.lock_index;
        if (idx < LOCK_COUNT) begin
          want = apply_lock_op(in_ch.kind, lock_shadow[idx]);
          lock_shadow[idx] = want.word;
        end else begin
          want = '0;
        end
        owed_results.push_back(want);
      end
      pending = owed_results.size();
    end
  end

endmodule

>>> verif/reader_writer_lock_table_unit_tb.sv
// Testbench top for the reader-writer lock table: clock, reset, request and
// result drivers, watchdog and verdict. Depends on rwlt_pkg, rwlt_if, the block
// and rwlt_lock_checker.
`timescale 1ns / 1ps

module reader_writer_lock_table_unit_tb;
  import rwlt_pkg::*;

  localparam int          LOCK_COUNT     = 64;
  localparam int          HOT_LOCKS      = 8;
  localparam int          RANDOM_ITEMS   = 1600;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam logic [2:0]  KIND_UNUSED    = 3'd7;
  localparam int          SEND_IDLE [4]  = '{0, 67, 0, 16};
  localparam int          RECV_STALL [4] = '{0, 0, 67, 16};

  logic clk;
  logic rst_n;

  rwlt_in_if  in_ch ();
  rwlt_out_if out_ch ();

  int fail_count;
  int pending;
  int results_seen;
  int granted_seen;
  int misuse_seen;
  int requests_sent  = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit hold_off_req   = 1'b0;

  reader_writer_lock_table_unit #(
    .LOCK_COUNT(LOCK_COUNT)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rwlt_lock_checker #(
    .LOCK_COUNT(LOCK_COUNT)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .pending     (pending),
    .results_seen(results_seen),
    .granted_seen(granted_seen),
    .misuse_seen (misuse_seen)
  );

  // 50 MHz clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result sink: random stalls, plus one long hold-off counted here on request.
  initial begin : result_sink
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req && !hold_taken) begin
        hold_left  = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: ends the run when no word moves on either channel for too long.
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("%0t: no word accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // Offers one request word, with random idle cycles first, and waits until
  // it is taken. Valid stays high afterwards until the next falling edge.
  task automatic send_req(input logic [2:0] op, input logic [5:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.kind       <= op;
    in_ch.lock_index <= idx;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    requests_sent++;
  endtask

  // Holds the request channel idle until every owed result word has come.
  task automatic pause_until_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // One short session on a lock: mostly well-formed acquire and release
  // patterns on a few hot locks, the rest random noise over the whole table.
  task automatic run_session(inout int left);
    logic [5:0] idx;
    int         n;
    int         pick;
    idx  = ($urandom_range(9) == 0) ? 6'($urandom_range(LOCK_COUNT - 1))
                                    : 6'($urandom_range(HOT_LOCKS - 1));
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = $urandom_range(1, 4);
      repeat (n) send_req(KIND_TRY_SHARED, idx);
      repeat (n) send_req(KIND_REL_SHARED, idx);
      left -= 2 * n;
    end else if (pick < 70) begin
      n = $urandom_range(1, 3);
      send_req(KIND_REG_WRITER, idx);
      repeat (n) send_req(KIND_CLAIM_EXCL, idx);
      send_req(KIND_REL_EXCL, idx);
      left -= n + 2;
    end else if (pick < 85) begin
      send_req(KIND_TRY_EXCL, idx);
      send_req(KIND_REL_EXCL, idx);
      left -= 2;
    end else begin
      n = $urandom_range(1, 3);
      repeat (n) send_req(3'($urandom_range(7)), 6'($urandom_range(LOCK_COUNT - 1)));
      left -= n;
    end
  endtask

  initial begin : stimulus
    int left;
    int random_start;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.kind       = KIND_CLEAR;
    in_ch.lock_index = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every operation, each misuse, writer preference and the
    // unused code, on the first and last lock.
    send_req(KIND_REL_SHARED, 6'd0);    // misuse: no reader
    send_req(KIND_REL_EXCL, 6'd0);      // misuse: no owner
    send_req(KIND_CLAIM_EXCL, 6'd0);    // misuse: no waiting writer
    send_req(KIND_TRY_SHARED, 6'd0);
    send_req(KIND_TRY_EXCL, 6'd0);      // reader present: refused
    send_req(KIND_REG_WRITER, 6'd0);
    send_req(KIND_TRY_SHARED, 6'd0);    // writer waiting: refused
    send_req(KIND_CLAIM_EXCL, 6'd0);    // reader present: refused
    send_req(KIND_REL_SHARED, 6'd0);
    send_req(KIND_CLAIM_EXCL, 6'd0);
    send_req(KIND_TRY_EXCL, 6'd0);      // owner present: refused
    send_req(KIND_TRY_SHARED, 6'd0);
    send_req(KIND_REL_EXCL, 6'd0);
    send_req(KIND_REG_WRITER, 6'd0);
    send_req(KIND_TRY_EXCL, 6'd0);      // waiting writer does not block this
    send_req(KIND_CLAIM_EXCL, 6'd0);
    send_req(KIND_UNUSED, 6'd0);
    send_req(KIND_CLEAR, 6'd0);
    send_req(KIND_TRY_SHARED, 6'd63);
    send_req(KIND_UNUSED, 6'd63);
    send_req(KIND_CLEAR, 6'd63);
    pause_until_drained();

    // Random sessions under four idle and stall mixes; the first phase starts
    // with a long receiver hold-off so the block backs up into the requester.
    random_start = requests_sent;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = SEND_IDLE[phase];
      recv_stall_pct = RECV_STALL[phase];
      if (phase == 0) hold_off_req = 1'b1;
      left = RANDOM_ITEMS / 4;
      while (left > 0) run_session(left);
      pause_until_drained();
    end

    repeat (10) @(negedge clk);
    $display("Sent %0d lock requests (%0d random) after directed misuse cases; %0d results",
             requests_sent, requests_sent - random_start, results_seen);
    $display("checked with %0d granted and %0d misuse, under four idle/stall mixes.",
             granted_seen, misuse_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
